@@ rtl/hrc_pkg.sv @@
// Shared constants and types for the HLS to RGB converter.
package hrc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Hue is Q9.7 degrees
  localparam int HUE_W = 16;
  localparam logic [HUE_W-1:0] DEG60  = 16'd7680;
  localparam logic [HUE_W-1:0] DEG120 = 16'd15360;
  localparam logic [HUE_W-1:0] DEG180 = 16'd23040;
  localparam logic [HUE_W-1:0] DEG240 = 16'd30720;
  localparam logic [HUE_W-1:0] DEG360 = 16'd46080;

  // Offset into a ramp segment, never above 60 degrees
  localparam int T_W = 13;

  // 60 degrees = 15 << 9: ramp division is a shift and a divide by 15
  localparam int RAMP_SHIFT = 9;
  localparam int RAMP_DIV   = 15;
  localparam int RAMP_HALF  = 3840;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    SEG_LOW,
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL
  } seg_t;

  typedef struct packed {
    seg_t           seg;
    logic [T_W-1:0] t;
  } chan_t;

  localparam int CHAN_W = $bits(chan_t);

endpackage

@@ rtl/hls_to_rgb_converter.sv @@
// HLS to RGB converter top level: front half, queue, back half.
//
// Input channel in_*: one colour per transfer (hue Q9.7 degrees, lightness
// and saturation Q1.FRAC_BITS). Output channel out_*: one colour per input,
// red, green, blue in Q1.FRAC_BITS, in input order.
// Throughput: one colour per clock cycle, sustained while the receiver is ready.
// Path: from an input transfer to out_tvalid with no stall, a colour passes
//   two front stages (clamps and l*s product, then m1/m2 and hue segment),
//   the two-entry queue, two back stages (d*t product, then the reciprocal
//   multiply for the divide by 60 degrees) and the output register. The l*s,
//   d*t and reciprocal products each have a stage of their own.
// Reset (rst_n low, synchronous): all valid flags and the queue clear;
//   no output is presented until new input arrives.
// Receiver stall: the output register holds its transfer, the back stages
//   fill, then the queue, then the front; in_tready drops only once all of
//   them are full, and no colour is lost or repeated.
// No configuration and no kept state between colours.
module hls_to_rgb_converter
  import hrc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int W = FRAC_BITS + 1,
  localparam int IN_TDATA_W  = ((HUE_W + 2*W + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((3*W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // hue [15:0], lightness, saturation; zero padded
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // red, green, blue from bit 0 up; zero padded
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int QW = 1 + 4*W + 3*CHAN_W;

  // input field split
  logic [HUE_W-1:0] hue;
  logic [W-1:0]     lightness;
  logic [W-1:0]     saturation;

  assign hue        = in_tdata[HUE_W-1:0];
  assign lightness  = in_tdata[HUE_W +: W];
  assign saturation = in_tdata[HUE_W+W +: W];

  // front to queue
  logic         fr_valid, fr_ready, fr_grey;
  logic [W-1:0] fr_l, fr_m1, fr_m2, fr_d;
  chan_t [2:0]  fr_chan;

  // queue to back
  logic         bk_valid, bk_ready;
  logic [QW-1:0] q_push, q_pop;
  logic         bk_grey;
  logic [W-1:0] bk_l, bk_m1, bk_m2, bk_d;
  chan_t [2:0]  bk_chan;

  logic [W-1:0] red, green, blue;

  hrc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .hue        (hue),
    .lightness  (lightness),
    .saturation (saturation),
    .out_valid  (fr_valid),
    .out_ready  (fr_ready),
    .out_grey   (fr_grey),
    .out_l      (fr_l),
    .out_m1     (fr_m1),
    .out_m2     (fr_m2),
    .out_d      (fr_d),
    .out_chan   (fr_chan)
  );

  assign q_push = {fr_grey, fr_l, fr_m1, fr_m2, fr_d, fr_chan};

  hrc_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (q_push),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (q_pop)
  );

  assign bk_chan = q_pop[3*CHAN_W-1:0];
  assign bk_d    = q_pop[3*CHAN_W +: W];
  assign bk_m2   = q_pop[3*CHAN_W+W +: W];
  assign bk_m1   = q_pop[3*CHAN_W+2*W +: W];
  assign bk_l    = q_pop[3*CHAN_W+3*W +: W];
  assign bk_grey = q_pop[QW-1];

  hrc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (bk_valid),
    .in_ready  (bk_ready),
    .grey      (bk_grey),
    .l         (bk_l),
    .m1        (bk_m1),
    .m2        (bk_m2),
    .d         (bk_d),
    .chan      (bk_chan),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign out_tdata = OUT_TDATA_W'({blue, green, red});

endmodule

@@ rtl/hrc_fifo.sv @@
// Small register queue between the front and back halves.
module hrc_fifo
  import hrc_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/hrc_front.sv @@
// Front half: input clamps, l*s product, m1/m2 and per-channel hue segment.
module hrc_front
  import hrc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int W = FRAC_BITS + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [HUE_W-1:0]  hue,
  input  logic [W-1:0]      lightness,
  input  logic [W-1:0]      saturation,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_grey,
  output logic [W-1:0]      out_l,
  output logic [W-1:0]      out_m1,
  output logic [W-1:0]      out_m2,
  output logic [W-1:0]      out_d,
  output chan_t [2:0]       out_chan
);

  localparam int M_W   = W + 3;
  localparam int ANG_W = HUE_W + 2;
  localparam logic [W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W-1:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [M_W-1:0] ONE_S = signed'({3'b000, ONE});
  localparam logic signed [ANG_W-1:0] ANG120 = signed'({2'b00, DEG120});
  localparam logic signed [ANG_W-1:0] ANG360 = signed'({2'b00, DEG360});

  function automatic chan_t classify(input logic signed [ANG_W-1:0] ang);
    logic signed [ANG_W-1:0] a;
    logic [HUE_W-1:0]        ua;
    chan_t                   c;
    a = ang;
    if (a > ANG360) begin
      a = a - ANG360;
    end else if (a < 0) begin
      a = a + ANG360;
    end
    ua    = a[HUE_W-1:0];
    c.seg = SEG_LOW;
    c.t   = '0;
    if (ua < DEG60) begin
      c.seg = SEG_RISE;
      c.t   = ua[T_W-1:0];
    end else if (ua < DEG180) begin
      c.seg = SEG_HIGH;
    end else if (ua < DEG240) begin
      c.seg = SEG_FALL;
      c.t   = T_W'(DEG240 - ua);
    end
    return c;
  endfunction

  // stage 1
  logic               f1_v_r;
  logic [HUE_W-1:0]   f1_h_r;
  logic [W-1:0]       f1_l_r;
  logic [W-1:0]       f1_s_r;
  logic [2*W-1:0]     f1_prod_r;
  // stage 2
  logic               f2_v_r;
  logic               f2_grey_r;
  logic [W-1:0]       f2_l_r;
  logic [W-1:0]       f2_m1_r;
  logic [W-1:0]       f2_m2_r;
  logic [W-1:0]       f2_d_r;
  chan_t [2:0]        f2_chan_r;

  logic               f1_ready;
  logic               f2_ready;
  logic [HUE_W-1:0]   h_red;
  logic [W-1:0]       l_cl;
  logic [W-1:0]       s_cl;
  logic [2*W-1:0]     prod_rnd;
  logic [W-1:0]       p;
  logic signed [M_W-1:0] lx, sx, px;
  logic signed [M_W-1:0] m2_raw, m2_cl, m1_raw, m1_cl;
  logic signed [ANG_W-1:0] h_s;
  chan_t [2:0]        chan;

  assign f2_ready  = !f2_v_r || out_ready;
  assign f1_ready  = !f1_v_r || f2_ready;
  assign in_ready  = f1_ready;
  assign out_valid = f2_v_r;

  always_comb begin
    h_red = (hue >= DEG360) ? hue - DEG360 : hue;
    l_cl  = (lightness > ONE) ? ONE : lightness;
    s_cl  = (saturation > ONE) ? ONE : saturation;
  end

  always_comb begin
    prod_rnd = f1_prod_r + (2*W)'(HALF);
    p        = prod_rnd[FRAC_BITS +: W];
    lx       = signed'(M_W'(f1_l_r));
    sx       = signed'(M_W'(f1_s_r));
    px       = signed'(M_W'(p));
    if (f1_l_r <= HALF) begin
      m2_raw = lx + px;
    end else begin
      m2_raw = lx + sx - px;
    end
    if (m2_raw < 0) begin
      m2_cl = '0;
    end else if (m2_raw > ONE_S) begin
      m2_cl = ONE_S;
    end else begin
      m2_cl = m2_raw;
    end
    m1_raw = lx + lx - m2_cl;
    if (m1_raw < 0) begin
      m1_cl = '0;
    end else if (m1_raw > m2_cl) begin
      m1_cl = m2_cl;
    end else begin
      m1_cl = m1_raw;
    end
    // red, green, blue sit at hue+120, hue, hue-120
    h_s     = signed'({2'b00, f1_h_r});
    chan[0] = classify(h_s + ANG120);
    chan[1] = classify(h_s);
    chan[2] = classify(h_s - ANG120);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      if (f1_ready) begin
        f1_v_r <= in_valid;
      end
      if (f2_ready) begin
        f2_v_r <= f1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f1_ready && in_valid) begin
      f1_h_r    <= h_red;
      f1_l_r    <= l_cl;
      f1_s_r    <= s_cl;
      f1_prod_r <= l_cl * s_cl;
    end
    if (f2_ready && f1_v_r) begin
      f2_grey_r <= (f1_s_r == '0);
      f2_l_r    <= f1_l_r;
      f2_m1_r   <= m1_cl[W-1:0];
      f2_m2_r   <= m2_cl[W-1:0];
      f2_d_r    <= m2_cl[W-1:0] - m1_cl[W-1:0];
      f2_chan_r <= chan;
    end
  end

  assign out_grey = f2_grey_r;
  assign out_l    = f2_l_r;
  assign out_m1   = f2_m1_r;
  assign out_m2   = f2_m2_r;
  assign out_d    = f2_d_r;
  assign out_chan = f2_chan_r;

endmodule

@@ rtl/hrc_back.sv @@
// Back half: ramp interpolation per channel and output register.
module hrc_back
  import hrc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int W = FRAC_BITS + 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         grey,
  input  logic [W-1:0] l,
  input  logic [W-1:0] m1,
  input  logic [W-1:0] m2,
  input  logic [W-1:0] d,
  input  chan_t [2:0]  chan,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] red,
  output logic [W-1:0] green,
  output logic [W-1:0] blue
);

  localparam int PW = W + T_W + 1;          // d*t plus rounding constant
  localparam int VW = PW - RAMP_SHIFT;      // width after the shift
  // floor(2^VW / 15): reciprocal estimate is low by at most one
  localparam logic [VW-1:0] RECIP = VW'(((64'd1 << VW) - 64'd1) / RAMP_DIV);
  localparam logic [VW-1:0] DIV_C = VW'(RAMP_DIV);

  logic            b1_v_r;
  logic [PW-1:0]   b1_sum_r [3];
  seg_t            b1_seg_r [3];
  logic            b1_grey_r;
  logic [W-1:0]    b1_l_r, b1_m1_r, b1_m2_r;

  logic            b2_v_r;
  logic [VW-1:0]   b2_v_val_r [3];
  logic [VW-1:0]   b2_q0_r [3];
  seg_t            b2_seg_r [3];
  logic            b2_grey_r;
  logic [W-1:0]    b2_l_r, b2_m1_r, b2_m2_r;

  logic            o_v_r;
  logic [W-1:0]    o_ch_r [3];

  logic            o_ready, b2_ready, b1_ready;
  logic [VW-1:0]   sh_val [3];
  logic [2*VW-1:0] recip_prod [3];
  logic [VW-1:0]   rem [3];
  logic [VW-1:0]   q [3];
  logic [W-1:0]    ramp [3];
  logic [W-1:0]    ch [3];

  assign o_ready  = !o_v_r || out_ready;
  assign b2_ready = !b2_v_r || o_ready;
  assign b1_ready = !b1_v_r || b2_ready;
  assign in_ready = b1_ready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh_val[i]     = b1_sum_r[i][PW-1:RAMP_SHIFT];
      recip_prod[i] = sh_val[i] * RECIP;
      rem[i]        = b2_v_val_r[i] - ((b2_q0_r[i] << 4) - b2_q0_r[i]);
      q[i]          = (rem[i] >= DIV_C) ? b2_q0_r[i] + 1'b1 : b2_q0_r[i];
      ramp[i]       = b2_m1_r + q[i][W-1:0];
      case (b2_seg_r[i])
        SEG_LOW:  ch[i] = b2_m1_r;
        SEG_RISE: ch[i] = ramp[i];
        SEG_HIGH: ch[i] = b2_m2_r;
        SEG_FALL: ch[i] = ramp[i];
        default:  ch[i] = b2_m1_r;
      endcase
      if (b2_grey_r) begin
        ch[i] = b2_l_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_v_r <= in_valid;
      end
      if (b2_ready) begin
        b2_v_r <= b1_v_r;
      end
      if (o_ready) begin
        o_v_r <= b2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_ready && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        b1_sum_r[i] <= PW'(d * chan[i].t) + PW'(RAMP_HALF);
        b1_seg_r[i] <= chan[i].seg;
      end
      b1_grey_r <= grey;
      b1_l_r    <= l;
      b1_m1_r   <= m1;
      b1_m2_r   <= m2;
    end
    if (b2_ready && b1_v_r) begin
      for (int i = 0; i < 3; i++) begin
        b2_v_val_r[i] <= sh_val[i];
        b2_q0_r[i]    <= recip_prod[i][2*VW-1:VW];
        b2_seg_r[i]   <= b1_seg_r[i];
      end
      b2_grey_r <= b1_grey_r;
      b2_l_r    <= b1_l_r;
      b2_m1_r   <= b1_m1_r;
      b2_m2_r   <= b1_m2_r;
    end
    if (o_ready && b2_v_r) begin
      for (int i = 0; i < 3; i++) begin
        o_ch_r[i] <= ch[i];
      end
    end
  end

  assign out_valid = o_v_r;
  assign red       = o_ch_r[0];
  assign green     = o_ch_r[1];
  assign blue      = o_ch_r[2];

endmodule

@@ rtl/hrc_checker.sv @@
// Port-level checks for the HLS to RGB converter, bound to the top level.
module hrc_checker
  import hrc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int W = FRAC_BITS + 1,
  localparam int OUT_TDATA_W = ((3*W + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled output transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // reset empties the pipeline
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // back-pressure on the input only follows a stalled output
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without a stalled output");

endmodule

bind hls_to_rgb_converter hrc_checker #(.FRAC_BITS(FRAC_BITS)) u_hrc_checker (.*);

@@ verif/tb_hls_to_rgb_converter.sv @@
// Self-checking testbench for the HLS to RGB colour converter stream block.
`timescale 1ns / 100ps

module tb_hls_to_rgb_converter;
  import hrc_pkg::*;

  localparam int FW          = FRAC_BITS_DEF + 1;            // 17-bit fractions
  localparam int IN_TDATA_W  = ((HUE_W + 2*FW + 7) / 8) * 8;  // 56
  localparam int OUT_TDATA_W = ((3*FW + 7) / 8) * 8;          // 56
  localparam int IN_PAD_W    = IN_TDATA_W - HUE_W - 2*FW;

  // Angles as wide integers for the channel arithmetic
  localparam longint HUE_60   = longint'(DEG60);
  localparam longint HUE_120  = longint'(DEG120);
  localparam longint HUE_180  = longint'(DEG180);
  localparam longint HUE_240  = longint'(DEG240);
  localparam longint HUE_FULL = longint'(DEG360);
  localparam longint FRAC_ONE = longint'(1) << FRAC_BITS_DEF;

  localparam int RAND_HALF    = 790;   // random colours per half of the random run
  localparam int HOLD_CYCLES  = 64;    // long receiver hold-off
  localparam int HOLD_AT      = 600;   // input transfers before the hold-off starts
  localparam int SETTLE       = 20;    // cycles after the last colour, well over latency
  localparam int IDLE_LIMIT   = 1000;  // cycles without any transfer before giving up
  localparam int REPORT_CAP   = 40;

  // Result colour, red in the lowest bits as on out_tdata
  typedef struct packed {
    logic [FW-1:0] blue;
    logic [FW-1:0] green;
    logic [FW-1:0] red;
  } rgb_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [IN_TDATA_W-1:0] pending_q [$];   // colours waiting to be offered
  rgb_t                  rgb_expect_q [$]; // predicted colours, oldest first

  bit in_xfer = 1'b0;   // an input transfer took place at the last rising edge
  int n_queued   = 0;   // colours handed to the driver
  int n_sent     = 0;   // input transfers
  int n_checked  = 0;   // output transfers matched against a prediction
  int n_errors   = 0;
  int n_grey     = 0;
  int n_clamped  = 0;
  int idle_cycles = 0;

  hls_to_rgb_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Colour predictor
  // ---------------------------------------------------------------------------

  // Value ramp of one channel: rises m1 -> m2 over the first 60 degrees, holds m2
  // to 180, falls back to m1 by 240 and holds m1 beyond. Only angles strictly
  // above 360 or below zero are wrapped, so a channel angle of exactly 360
  // lands in the low segment at m1, the same level that angle 0 gives.
  function automatic longint ramp_level(longint lo, longint hi, longint angle);
    longint span;
    span = hi - lo;
    if (angle > HUE_FULL)
      angle -= HUE_FULL;
    else if (angle < 0)
      angle += HUE_FULL;
    if (angle < HUE_60)
      return lo + (span * angle + HUE_60 / 2) / HUE_60;
    if (angle < HUE_180)
      return hi;
    if (angle < HUE_240)
      return lo + (span * (HUE_240 - angle) + HUE_60 / 2) / HUE_60;
    return lo;
  endfunction

  function automatic rgb_t predict_colour(logic [HUE_W-1:0] hue, logic [FW-1:0] light,
                                          logic [FW-1:0] sat);
    longint h, l, s, ls, m1, m2;
    rgb_t   c;
    h = hue;
    l = light;
    s = sat;
    // hue of 360 or more is brought back by one turn; fractions cap at 1.0
    if (h >= HUE_FULL) h -= HUE_FULL;
    if (l > FRAC_ONE) l = FRAC_ONE;
    if (s > FRAC_ONE) s = FRAC_ONE;
    ls = (l * s + FRAC_ONE / 2) >>> FRAC_BITS_DEF;   // l*s rounded half up
    m2 = (l <= FRAC_ONE / 2) ? l + ls : l + s - ls;
    if (m2 < 0) m2 = 0;
    if (m2 > FRAC_ONE) m2 = FRAC_ONE;
    m1 = 2 * l - m2;
    if (m1 < 0) m1 = 0;
    if (m1 > m2) m1 = m2;
    if (s == 0) begin
      // no saturation: plain grey at the lightness
      c.red   = FW'(l);
      c.green = FW'(l);
      c.blue  = FW'(l);
    end else begin
      c.red   = FW'(ramp_level(m1, m2, h + HUE_120));
      c.green = FW'(ramp_level(m1, m2, h));
      c.blue  = FW'(ramp_level(m1, m2, h - HUE_120));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_colour(int hue, int light, int sat);
    pending_q.push_back({{IN_PAD_W{1'b0}}, FW'(sat), FW'(light), HUE_W'(hue)});
    n_queued++;
  endtask

  // Lightness or saturation: mostly legal fractions, with the edges, small values,
  // values just around one half and the odd over-range code mixed in.
  function automatic int rand_frac();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return int'(FRAC_ONE);
      2: return int'(FRAC_ONE / 2) + $urandom_range(0, 2) - 1;
      3: return $urandom_range(0, (1 << FW) - 1);
      4: return $urandom_range(0, 16);
      default: return $urandom_range(0, int'(FRAC_ONE));
    endcase
  endfunction

  // Hue: mostly below 360 degrees, sometimes on or next to a segment boundary,
  // sometimes anywhere in the 16-bit field.
  function automatic int rand_hue();
    int marks [6];
    marks = '{0, int'(DEG60), int'(DEG120), int'(DEG180), int'(DEG240),
              int'(DEG360) - 1};
    case ($urandom_range(0, 19))
      0, 1: return (marks[$urandom_range(0, 5)] + $urandom_range(0, 2) - 1) & 16'hFFFF;
      2:    return $urandom_range(0, 16'hFFFF);
      default: return $urandom_range(0, int'(DEG360) - 1);
    endcase
  endfunction

  // Hold the sender back until every predicted colour has come out.
  task automatic wait_drained();
    do @(negedge clk); while (n_checked != n_queued);
    @(posedge clk);
  endtask

  task automatic report_error(string msg);
    if (n_errors < REPORT_CAP)
      $display("ERROR %0t ns: %s", $time, msg);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed colours, then two halves of random colours with
  // a full drain between each part.
  // ---------------------------------------------------------------------------
  initial begin
    // directed colours, all queued before reset is released
    queue_colour(0,     32768, 65536);   // pure red
    queue_colour(7680,  32768, 65536);   // yellow, ramp top
    queue_colour(15360, 32768, 65536);   // green
    queue_colour(23040, 32768, 65536);   // cyan, end of the hold segment
    queue_colour(30720, 32768, 65536);   // blue; red channel angle exactly 360
    queue_colour(38400, 32768, 65536);   // magenta
    queue_colour(46079, 40000, 50000);   // largest legal hue
    queue_colour(46080, 40000, 50000);   // hue of a full turn, reduced to 0
    queue_colour(65535, 20000, 30000);   // largest hue code
    queue_colour(3840,  20000, 50000);   // mid rising ramp
    queue_colour(26880, 45000, 30000);   // mid falling ramp
    queue_colour(12345, 0,     65536);   // black
    queue_colour(12345, 65536, 65536);   // white
    queue_colour(12345, 32768, 0);       // grey at one half
    queue_colour(12345, 0,     0);       // black grey
    queue_colour(5000,  131071, 131071); // both fractions over range
    queue_colour(5000,  131071, 0);      // over-range grey
    queue_colour(5000,  32768, 131071);  // saturation over range
    queue_colour(9000,  32769, 40000);   // lightness just over one half
    queue_colour(9000,  32767, 40000);   // lightness just under one half
    queue_colour(1,     1,     1);
    queue_colour(33000, 65535, 65535);
    queue_colour(16'hAAAA, 17'h15555, 17'h0AAAA);
    queue_colour(16'h5555, 17'h0AAAA, 17'h15555);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    wait_drained();
    repeat (RAND_HALF) queue_colour(rand_hue(), rand_frac(), rand_frac());
    wait_drained();
    repeat (RAND_HALF) queue_colour(rand_hue(), rand_frac(), rand_frac());
    wait_drained();

    repeat (SETTLE) @(posedge clk);
    if (rgb_expect_q.size() != 0)
      report_error($sformatf("%0d predicted colours never came out",
                             rgb_expect_q.size()));

    $display("Checked %0d of %0d colours: %0d grey, %0d with hue or fractions out of range.",
             n_checked, n_sent, n_grey, n_clamped);
    $display("Sender ran in bursts with gaps and drains; receiver stalled at random %s",
             $sformatf("and held off %0d cycles once.", HOLD_CYCLES));
    if (n_errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers colours in bursts of random length with random gaps. A
  // colour stays on in_tdata until a transfer has been seen at a rising edge.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_xfer)) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_tdata  <= pending_q.pop_front();
        in_tvalid <= 1'b1;
        burst_left--;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: runs of ready and short stalls of random length, with a long
  // hold-off once part of the random run has gone through, so that the
  // pipeline and its queue fill and in_tready drops.
  // ---------------------------------------------------------------------------
  int  ready_left = 0;
  int  stall_left = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;

  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if (!hold_done && n_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else begin
        if (ready_left == 0) begin
          ready_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
          stall_left = $urandom_range(1, 5);
        end
        ready_left--;
        rdy = 1'b1;
      end
    end
    out_tready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts each input transfer and checks each output transfer
  // against the oldest prediction, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rgb_t             got, want;
    logic [HUE_W-1:0] hue;
    logic [FW-1:0]    light, sat;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[3*FW-1:0];
      if (rgb_expect_q.size() == 0) begin
        report_error($sformatf("colour %h with none predicted", got));
      end else begin
        want = rgb_expect_q.pop_front();
        if (got.red !== want.red)
          report_error($sformatf("colour %0d red %h, want %h", n_checked, got.red, want.red));
        if (got.green !== want.green)
          report_error($sformatf("colour %0d green %h, want %h", n_checked, got.green,
                                 want.green));
        if (got.blue !== want.blue)
          report_error($sformatf("colour %0d blue %h, want %h", n_checked, got.blue,
                                 want.blue));
        n_checked++;
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      hue   = in_tdata[HUE_W-1:0];
      light = in_tdata[HUE_W +: FW];
      sat   = in_tdata[HUE_W+FW +: FW];
      rgb_expect_q.push_back(predict_colour(hue, light, sat));
      if (sat == 0) n_grey++;
      if (hue >= DEG360 || light > FRAC_ONE || sat > FRAC_ONE) n_clamped++;
      n_sent++;
      in_xfer <= 1'b1;
    end else begin
      in_xfer <= 1'b0;
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles with no transfer", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
